>>> hw/rtl/att_pkg.sv
// ----------------------------------------------------------------------------
// att_pkg
// Types and constants shared by the allocation tracking table modules.
// ----------------------------------------------------------------------------
package att_pkg;

	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int ADDR_W   = 48;
	localparam int SIZE_W   = 32;
	localparam int COUNT_W  = 16;
	localparam int SEQ_W    = 32;
	localparam int OCC_W    = 48;

	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int DEF_ADDR_BITS     = 48;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC       = 2'd0,
		MODE_ALLOC_ARRAY = 2'd1,
		MODE_REALLOC     = 2'd2,
		MODE_FREE        = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_UNKNOWN = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_FAILED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RELEASE,
		ST_RECORD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rel_step;
		logic rec_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

>>> hw/rtl/allocation_tracking_table.sv
// ----------------------------------------------------------------------------
// allocation_tracking_table
// Tracks live heap allocations in a table of TABLE_ENTRIES slots.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (mode, address, old_address, size, count) enter on in_valid /
//   in_stall; one result per request leaves on out_valid / out_stall with
//   status, new_id, freed_size, occupied_bytes, alloc_total and free_total.
//   A transfer happens on a clock edge with valid high and stall low.
//   Each request walks the whole table, one slot per cycle through the
//   registered read port of the entry RAM, to find the lowest matching and
//   the lowest free slot. Then a release step and a record step follow.
//   The result is registered in the record step, and the next request can
//   be taken only once that step is done.
//   in_stall is high while a request is in progress.
//   If the receiver stalls, the result register holds; the next request can
//   still be taken and walked, and its record step waits for the register.
//   Reset clears all slot valid bits, the byte total and both counters at
//   once; entry contents need no clearing.
//   Addresses compare on their low ADDR_BITS bits (all ADDR_W bits if ADDR_BITS is larger).
// ----------------------------------------------------------------------------
module allocation_tracking_table #(
	parameter int TABLE_ENTRIES = att_pkg::DEF_TABLE_ENTRIES,
	parameter int ADDR_BITS     = att_pkg::DEF_ADDR_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [att_pkg::MODE_W-1:0]    mode,
	input  logic [att_pkg::ADDR_W-1:0]    address,
	input  logic [att_pkg::ADDR_W-1:0]    old_address,
	input  logic [att_pkg::SIZE_W-1:0]    size,
	input  logic [att_pkg::COUNT_W-1:0]   count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [att_pkg::STATUS_W-1:0]  status,
	output logic [att_pkg::SEQ_W-1:0]     new_id,
	output logic [att_pkg::SIZE_W-1:0]    freed_size,
	output logic [att_pkg::OCC_W-1:0]     occupied_bytes,
	output logic [att_pkg::SEQ_W-1:0]     alloc_total,
	output logic [att_pkg::SEQ_W-1:0]     free_total
);

	att_pkg::cmd_t cmd;
	att_pkg::sts_t sts;

	att_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	att_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ADDR_BITS     (ADDR_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.address        (address),
		.old_address    (old_address),
		.size           (size),
		.count          (count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.new_id         (new_id),
		.freed_size     (freed_size),
		.occupied_bytes (occupied_bytes),
		.alloc_total    (alloc_total),
		.free_total     (free_total)
	);

	// a taken request keeps the input side closed while it is walked
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while busy");

	// a result appears only from a record step
	a_result_from_record: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.rec_step))
		else $error("result without record step");

	// never overwrite a result the receiver is still holding off
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rec_step |-> (!out_valid || !out_stall))
		else $error("result register overwritten");

	// walk ends only while a request is in progress
	a_scan_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.scan_done |-> in_stall)
		else $error("table walk finished while idle");

endmodule

>>> hw/rtl/att_ram.sv
// ----------------------------------------------------------------------------
// att_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module att_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/att_ctrl.sv
// ----------------------------------------------------------------------------
// att_ctrl
// Sequencer for one event: accept, table walk, release step, record step.
// ----------------------------------------------------------------------------
module att_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  att_pkg::sts_t sts,
	output att_pkg::cmd_t cmd
);

	att_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= att_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			att_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = att_pkg::ST_SCAN;
				end
			end
			att_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = att_pkg::ST_RELEASE;
				end
			end
			att_pkg::ST_RELEASE: begin
				state_nxt = att_pkg::ST_RECORD;
			end
			att_pkg::ST_RECORD: begin
				if (sts.out_free) begin
					state_nxt = att_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = att_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			att_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			att_pkg::ST_RELEASE: begin
				cmd.rel_step = 1'b1;
			end
			att_pkg::ST_RECORD: begin
				// hold until the output register can take the result
				cmd.rec_step = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> hw/rtl/att_datapath.sv
// ----------------------------------------------------------------------------
// att_datapath
// Entry storage, table walk, counters, occupancy and the result register.
// ----------------------------------------------------------------------------
module att_datapath #(
	parameter int TABLE_ENTRIES = att_pkg::DEF_TABLE_ENTRIES,
	parameter int ADDR_BITS     = att_pkg::DEF_ADDR_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  att_pkg::cmd_t                 cmd,
	output att_pkg::sts_t                 sts,
	input  logic [att_pkg::MODE_W-1:0]    mode,
	input  logic [att_pkg::ADDR_W-1:0]    address,
	input  logic [att_pkg::ADDR_W-1:0]    old_address,
	input  logic [att_pkg::SIZE_W-1:0]    size,
	input  logic [att_pkg::COUNT_W-1:0]   count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [att_pkg::STATUS_W-1:0]  status,
	output logic [att_pkg::SEQ_W-1:0]     new_id,
	output logic [att_pkg::SIZE_W-1:0]    freed_size,
	output logic [att_pkg::OCC_W-1:0]     occupied_bytes,
	output logic [att_pkg::SEQ_W-1:0]     alloc_total,
	output logic [att_pkg::SEQ_W-1:0]     free_total
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int KEY_W  = (ADDR_BITS < att_pkg::ADDR_W) ? ADDR_BITS : att_pkg::ADDR_W;
	localparam int SZ_W   = att_pkg::SIZE_W;
	localparam int OCC_W  = att_pkg::OCC_W;
	localparam int PROD_W = att_pkg::SIZE_W + att_pkg::COUNT_W;
	localparam int WORD_W = KEY_W + SZ_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// captured request
	att_pkg::mode_t              mode_q;
	logic [KEY_W-1:0]            addr_key_q;
	logic [KEY_W-1:0]            look_key_q;
	logic                        look_en_q;
	logic [SZ_W-1:0]             size_q;
	logic [att_pkg::COUNT_W-1:0] count_q;
	logic [PROD_W-1:0]           prod_q;

	// table state
	logic [TABLE_ENTRIES-1:0]    valid_q;
	logic [OCC_W-1:0]            bytes_q;
	logic [att_pkg::SEQ_W-1:0]   alloc_cnt_q;
	logic [att_pkg::SEQ_W-1:0]   free_cnt_q;

	// walk
	logic [IDX_W-1:0]            scan_idx_q;
	logic                        scan_on_q;
	logic                        rd_s1;
	logic                        last_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [WORD_W-1:0]           rd_word;
	logic                        match_found_q;
	logic [IDX_W-1:0]            match_idx_q;
	logic [SZ_W-1:0]             match_size_q;
	logic                        free_found_q;
	logic [IDX_W-1:0]            free_idx_q;

	// decision, taken in the release step
	logic                        rec_do_q;
	logic [IDX_W-1:0]            rec_slot_q;
	logic [SZ_W-1:0]             rec_size_q;
	att_pkg::status_t            status_q;
	logic [SZ_W-1:0]             freed_q;

	logic                        dec_rel;
	logic                        dec_rec;
	logic [IDX_W-1:0]            dec_slot;
	logic [SZ_W-1:0]             dec_size;
	att_pkg::status_t            dec_status;
	logic [SZ_W-1:0]             sat_prod;
	logic                        addr_zero;

	logic [OCC_W-1:0]            rel_ext;
	logic [OCC_W:0]              add_sum;
	logic [OCC_W-1:0]            bytes_added;

	logic                        out_valid_q;

	// ---------------------------------------------------------------- capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q     <= att_pkg::mode_t'(mode);
			addr_key_q <= address[KEY_W-1:0];
			size_q     <= size;
			count_q    <= count;
			if (att_pkg::mode_t'(mode) == att_pkg::MODE_REALLOC) begin
				look_key_q <= old_address[KEY_W-1:0];
				look_en_q  <= |old_address[KEY_W-1:0];
			end else begin
				look_key_q <= address[KEY_W-1:0];
				look_en_q  <= (att_pkg::mode_t'(mode) == att_pkg::MODE_FREE) &&
					(|address[KEY_W-1:0]);
			end
		end
		prod_q <= PROD_W'(size_q) * PROD_W'(count_q);
	end

	// ---------------------------------------------------------------- storage
	att_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.rec_step && rec_do_q),
		.waddr (rec_slot_q),
		.wdata ({addr_key_q, rec_size_q}),
		.re    (scan_on_q),
		.raddr (scan_idx_q),
		.rdata (rd_word)
	);

	// ---------------------------------------------------------------- walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_on_q  <= 1'b0;
			scan_idx_q <= '0;
			rd_s1      <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			rd_s1   <= scan_on_q;
			last_s1 <= scan_on_q && (scan_idx_q == LAST_IDX);
			if (cmd.accept) begin
				scan_on_q  <= 1'b1;
				scan_idx_q <= '0;
			end else if (scan_on_q) begin
				if (scan_idx_q == LAST_IDX) begin
					scan_on_q <= 1'b0;
				end else begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (cmd.accept) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (rd_s1) begin
			// keep the lowest matching slot and the lowest free slot
			if (!match_found_q && look_en_q && valid_q[idx_s1] &&
				rd_word[SZ_W +: KEY_W] == look_key_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_s1;
				match_size_q  <= rd_word[SZ_W-1:0];
			end
			if (!free_found_q && !valid_q[idx_s1]) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end
	end

	assign sts.scan_done = rd_s1 && last_s1;

	// ---------------------------------------------------------------- decide
	assign sat_prod  = (|prod_q[PROD_W-1:SZ_W]) ? '1 : prod_q[SZ_W-1:0];
	assign addr_zero = ~|addr_key_q;

	always_comb begin
		dec_rel    = 1'b0;
		dec_rec    = 1'b0;
		dec_slot   = free_idx_q;
		dec_size   = size_q;
		dec_status = att_pkg::STAT_OK;
		case (mode_q)
			att_pkg::MODE_ALLOC, att_pkg::MODE_ALLOC_ARRAY: begin
				if (mode_q == att_pkg::MODE_ALLOC_ARRAY) begin
					dec_size = sat_prod;
				end
				if (addr_zero) begin
					dec_status = att_pkg::STAT_FAILED;
				end else if (!free_found_q) begin
					dec_status = att_pkg::STAT_FULL;
				end else begin
					dec_rec = 1'b1;
				end
			end
			att_pkg::MODE_REALLOC: begin
				if (look_en_q && !match_found_q) begin
					dec_status = att_pkg::STAT_UNKNOWN;
				end else if (match_found_q && size_q == '0) begin
					dec_rel = 1'b1;
				end else if (addr_zero) begin
					dec_status = att_pkg::STAT_FAILED;
				end else begin
					dec_rel = match_found_q;
					// the slot just released may be the lowest free one
					if (match_found_q && (!free_found_q || match_idx_q < free_idx_q)) begin
						dec_slot = match_idx_q;
					end
					if (free_found_q || match_found_q) begin
						dec_rec = 1'b1;
					end else begin
						dec_status = att_pkg::STAT_FULL;
					end
				end
			end
			att_pkg::MODE_FREE: begin
				if (match_found_q) begin
					dec_rel = 1'b1;
				end else begin
					dec_status = att_pkg::STAT_UNKNOWN;
				end
			end
			default: begin
				dec_status = att_pkg::STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rel_step) begin
			rec_do_q   <= dec_rec;
			rec_slot_q <= dec_slot;
			rec_size_q <= dec_size;
			status_q   <= dec_status;
			freed_q    <= dec_rel ? match_size_q : '0;
		end
	end

	// ---------------------------------------------------------------- update
	assign rel_ext     = OCC_W'(match_size_q);
	assign add_sum     = {1'b0, bytes_q} + (OCC_W + 1)'(rec_size_q);
	assign bytes_added = add_sum[OCC_W] ? '1 : add_sum[OCC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			bytes_q     <= '0;
			alloc_cnt_q <= '0;
			free_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rel_step && dec_rel) begin
				valid_q[match_idx_q] <= 1'b0;
				free_cnt_q           <= free_cnt_q + 1'b1;
				bytes_q              <= (bytes_q >= rel_ext) ? bytes_q - rel_ext : '0;
			end
			if (cmd.rec_step && rec_do_q) begin
				valid_q[rec_slot_q] <= 1'b1;
				alloc_cnt_q         <= alloc_cnt_q + 1'b1;
				bytes_q             <= bytes_added;
			end
			if (cmd.rec_step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rec_step) begin
			status         <= status_q;
			new_id         <= rec_do_q ? alloc_cnt_q : '0;
			freed_size     <= freed_q;
			occupied_bytes <= rec_do_q ? bytes_added : bytes_q;
			alloc_total    <= rec_do_q ? alloc_cnt_q + 1'b1 : alloc_cnt_q;
			free_total     <= free_cnt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

>>> tb/att_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_event_checker
// Watches both channels of the allocation tracking table. It keeps its own
// copy of the slot table and counters, works out the result of every
// accepted request, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module att_event_checker #(
	parameter int TABLE_ENTRIES = att_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [att_pkg::MODE_W-1:0]    mode,
	input  logic [att_pkg::ADDR_W-1:0]    address,
	input  logic [att_pkg::ADDR_W-1:0]    old_address,
	input  logic [att_pkg::SIZE_W-1:0]    size,
	input  logic [att_pkg::COUNT_W-1:0]   count,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [att_pkg::STATUS_W-1:0]  status,
	input  logic [att_pkg::SEQ_W-1:0]     new_id,
	input  logic [att_pkg::SIZE_W-1:0]    freed_size,
	input  logic [att_pkg::OCC_W-1:0]     occupied_bytes,
	input  logic [att_pkg::SEQ_W-1:0]     alloc_total,
	input  logic [att_pkg::SEQ_W-1:0]     free_total,
	output int unsigned                   failures,
	output int                            pending
);
	import att_pkg::*;

	localparam logic [OCC_W-1:0] OCC_MAX = '1;

	typedef struct packed {
		status_t            status;
		logic [SEQ_W-1:0]   new_id;
		logic [SIZE_W-1:0]  freed;
		logic [OCC_W-1:0]   occupied;
		logic [SEQ_W-1:0]   allocs;
		logic [SEQ_W-1:0]   frees;
	} outcome_t;

	logic               slot_live  [TABLE_ENTRIES];
	logic [ADDR_W-1:0]  slot_addr  [TABLE_ENTRIES];
	logic [SIZE_W-1:0]  slot_bytes [TABLE_ENTRIES];
	logic [OCC_W-1:0]   bytes_live;
	logic [SEQ_W-1:0]   alloc_cnt;
	logic [SEQ_W-1:0]   free_cnt;

	outcome_t pending_outcomes[$];
	int unsigned fail_count = 0;

	assign failures = fail_count;

	// lowest live slot holding the address, -1 if none
	function automatic int find_live(logic [ADDR_W-1:0] a);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (slot_live[i] && slot_addr[i] == a)
				return i;
		return -1;
	endfunction

	function automatic logic [SIZE_W-1:0] drop_slot(int i);
		logic [SIZE_W-1:0] s;
		s = slot_bytes[i];
		slot_live[i] = 1'b0;
		free_cnt++;
		bytes_live = (bytes_live >= s) ? bytes_live - s : '0;
		return s;
	endfunction

	function automatic status_t enter_slot(logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s,
			output logic [SEQ_W-1:0] id);
		int slot;
		logic [OCC_W:0] sum;
		id = '0;
		slot = -1;
		if (a == '0)
			return STAT_FAILED;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (!slot_live[i] && slot < 0)
				slot = i;
		if (slot < 0)
			return STAT_FULL;
		slot_live[slot] = 1'b1;
		slot_addr[slot] = a;
		slot_bytes[slot] = s;
		id = alloc_cnt;
		alloc_cnt++;
		sum = bytes_live + s;
		bytes_live = (sum > OCC_MAX) ? OCC_MAX : sum[OCC_W-1:0];
		return STAT_OK;
	endfunction

	function automatic outcome_t track_event(mode_t m, logic [ADDR_W-1:0] a,
			logic [ADDR_W-1:0] old, logic [SIZE_W-1:0] sz, logic [COUNT_W-1:0] cnt);
		outcome_t r;
		int hit;
		logic [SEQ_W-1:0] id;
		logic [SIZE_W+COUNT_W-1:0] prod;
		r.status = STAT_OK;
		r.freed = '0;
		id = '0;
		case (m)
			MODE_ALLOC: r.status = enter_slot(a, sz, id);
			MODE_ALLOC_ARRAY: begin
				prod = sz * cnt;
				if (prod > {SIZE_W{1'b1}})
					prod = {SIZE_W{1'b1}};
				r.status = enter_slot(a, prod[SIZE_W-1:0], id);
			end
			MODE_REALLOC: begin
				hit = -1;
				if (old != '0) begin
					hit = find_live(old);
					if (hit < 0)
						r.status = STAT_UNKNOWN;
				end
				if (r.status == STAT_OK) begin
					// size zero on a known entry only releases it
					if (hit >= 0 && sz == '0) begin
						r.freed = drop_slot(hit);
					end else if (a == '0) begin
						r.status = STAT_FAILED;
					end else begin
						if (hit >= 0)
							r.freed = drop_slot(hit);
						r.status = enter_slot(a, sz, id);
					end
				end
			end
			default: begin
				hit = (a == '0) ? -1 : find_live(a);
				if (hit < 0)
					r.status = STAT_UNKNOWN;
				else
					r.freed = drop_slot(hit);
			end
		endcase
		r.new_id = id;
		r.occupied = bytes_live;
		r.allocs = alloc_cnt;
		r.frees = free_cnt;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [OCC_W-1:0] want,
			logic [OCC_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				slot_live[i] = 1'b0;
			bytes_live = '0;
			alloc_cnt = '0;
			free_cnt = '0;
			pending_outcomes.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				pending_outcomes.push_back(track_event(mode_t'(mode), address, old_address,
					size, count));
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					$error("result with no request waiting: status %0d, new_id 0x%0h",
						status, new_id);
					fail_count++;
				end else begin
					want = pending_outcomes.pop_front();
					compare_field("status", OCC_W'(want.status), OCC_W'(status));
					compare_field("new_id", OCC_W'(want.new_id), OCC_W'(new_id));
					compare_field("freed_size", OCC_W'(want.freed), OCC_W'(freed_size));
					compare_field("occupied_bytes", want.occupied, occupied_bytes);
					compare_field("alloc_total", OCC_W'(want.allocs), OCC_W'(alloc_total));
					compare_field("free_total", OCC_W'(want.frees), OCC_W'(free_total));
				end
			end
			pending <= pending_outcomes.size();
		end
	end

endmodule

>>> tb/tb_allocation_tracking_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_allocation_tracking_table
// Drives allocate, array allocate, reallocate and free requests into the
// table: a directed set of corner cases, then random phases that fill the
// table, empty it and mix both, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_allocation_tracking_table;
	import att_pkg::*;

	localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
	localparam int RANDOM_ITEMS  = 1600;
	localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [MODE_W-1:0]    mode;
	logic [ADDR_W-1:0]    address;
	logic [ADDR_W-1:0]    old_address;
	logic [SIZE_W-1:0]    size;
	logic [COUNT_W-1:0]   count;
	logic                 out_valid;
	logic                 out_stall;
	logic [STATUS_W-1:0]  status;
	logic [SEQ_W-1:0]     new_id;
	logic [SIZE_W-1:0]    freed_size;
	logic [OCC_W-1:0]     occupied_bytes;
	logic [SEQ_W-1:0]     alloc_total;
	logic [SEQ_W-1:0]     free_total;
	int unsigned          failures;
	int                   pending;

	bit gaps_on = 1'b1;
	int sent = 0;
	logic [ADDR_W-1:0] live_addrs[$];

	allocation_tracking_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .address(address), .old_address(old_address),
		.size(size), .count(count),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .new_id(new_id), .freed_size(freed_size),
		.occupied_bytes(occupied_bytes), .alloc_total(alloc_total),
		.free_total(free_total)
	);

	att_event_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .address(address), .old_address(old_address),
		.size(size), .count(count),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .new_id(new_id), .freed_size(freed_size),
		.occupied_bytes(occupied_bytes), .alloc_total(alloc_total),
		.free_total(free_total),
		.failures(failures), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("allocation_tracking_table verification failed");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] any_addr();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[ADDR_W-1:0];
	endfunction

	function automatic int live_index(logic [ADDR_W-1:0] a);
		for (int i = 0; i < live_addrs.size(); i++)
			if (live_addrs[i] == a)
				return i;
		return -1;
	endfunction

	// a live address most of the time, otherwise null or a stranger
	function automatic logic [ADDR_W-1:0] known_addr(int hit_pct);
		if ($urandom_range(0, 99) < hit_pct && live_addrs.size() > 0)
			return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
		if ($urandom_range(0, 9) < 4)
			return '0;
		return any_addr();
	endfunction

	function automatic logic [ADDR_W-1:0] fresh_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 13 && live_addrs.size() > 0)
			return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
		if (r < 22)
			return ADDR_W'({$urandom_range(1, 4095), 4'h0});
		return any_addr();
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 14)
			return '1;
		if (r < 50)
			return SIZE_W'($urandom_range(1, 4096));
		return $urandom();
	endfunction

	function automatic logic [COUNT_W-1:0] rand_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 14)
			return '1;
		if (r < 60)
			return COUNT_W'($urandom_range(1, 16));
		return COUNT_W'($urandom_range(0, 65535));
	endfunction

	// present one request, hold it until taken, and track the live set
	task automatic send_event(mode_t m, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] old,
			logic [SIZE_W-1:0] sz, logic [COUNT_W-1:0] cnt);
		int gap;
		int idx;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		address <= a;
		old_address <= old;
		size <= sz;
		count <= cnt;
		do @(posedge clk); while (in_stall);
		sent++;
		case (m)
			MODE_ALLOC, MODE_ALLOC_ARRAY: begin
				if (a != '0 && live_addrs.size() < TABLE_ENTRIES)
					live_addrs.push_back(a);
			end
			MODE_REALLOC: begin
				idx = live_index(old);
				if (old == '0) begin
					if (a != '0 && live_addrs.size() < TABLE_ENTRIES)
						live_addrs.push_back(a);
				end else if (idx >= 0 && (sz == '0 || a != '0)) begin
					live_addrs.delete(idx);
					if (sz != '0)
						live_addrs.push_back(a);
				end
			end
			default: begin
				idx = live_index(a);
				if (idx >= 0)
					live_addrs.delete(idx);
			end
		endcase
	endtask

	task automatic random_event(int kind);
		int r;
		mode_t m;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] old;
		logic [SIZE_W-1:0] sz;
		r = $urandom_range(0, 99);
		case (kind)
			0: m = r < 55 ? MODE_ALLOC : r < 70 ? MODE_ALLOC_ARRAY :
				r < 85 ? MODE_REALLOC : MODE_FREE;
			1: m = r < 15 ? MODE_ALLOC : r < 20 ? MODE_ALLOC_ARRAY :
				r < 40 ? MODE_REALLOC : MODE_FREE;
			default: m = r < 30 ? MODE_ALLOC : r < 40 ? MODE_ALLOC_ARRAY :
				r < 65 ? MODE_REALLOC : MODE_FREE;
		endcase
		a = fresh_addr();
		old = any_addr();
		sz = rand_size();
		if (m == MODE_FREE)
			a = known_addr(82);
		if (m == MODE_REALLOC) begin
			old = known_addr(72);
			if ($urandom_range(0, 9) == 0)
				sz = '0;
		end
		send_event(m, a, old, sz, rand_count());
	endtask

	// drop valid and hold off until every result has come back
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// result side: while gaps are on, stall results at random
	initial begin
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			hold = gaps_on ? $urandom_range(0, 8) : 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				do @(posedge clk); while (!out_valid);
				repeat (hold - 1) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		int phase;
		int span;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ALLOC;
		address = '0;
		old_address = '0;
		size = '0;
		count = '0;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases on an empty table
		send_event(MODE_FREE, '0, '0, '0, '0);
		send_event(MODE_FREE, 48'h1234, '0, 32'd5, '0);
		send_event(MODE_ALLOC, '0, '0, 32'd100, '0);
		send_event(MODE_ALLOC, ADDR_TOP, ADDR_TOP, '1, '1);
		send_event(MODE_ALLOC, 48'h1, '0, '0, '0);
		send_event(MODE_ALLOC_ARRAY, 48'h1000, '0, '1, '1);
		send_event(MODE_ALLOC_ARRAY, 48'h2000, '0, 32'd3, 16'd5);
		send_event(MODE_ALLOC_ARRAY, 48'h3000, '0, 32'd77, '0);
		send_event(MODE_ALLOC_ARRAY, '0, '0, 32'd5, 16'd5);
		send_event(MODE_REALLOC, 48'h4000, '0, '0, '0);
		send_event(MODE_REALLOC, 48'h5000, 48'hdead, 32'd8, '0);
		send_event(MODE_REALLOC, 48'h6000, 48'h2000, '0, '0);
		send_event(MODE_REALLOC, '0, 48'h1000, 32'd9, '0);
		send_event(MODE_REALLOC, 48'h7000, 48'h1000, 32'd123, '0);
		send_event(MODE_REALLOC, '0, '0, 32'd5, '0);
		send_event(MODE_ALLOC, 48'h8000, '0, 32'd10, '0);
		send_event(MODE_ALLOC, 48'h8000, '0, 32'd20, '0);
		send_event(MODE_FREE, 48'h8000, '0, '0, '0);
		send_event(MODE_FREE, 48'h8000, '0, '0, '0);
		send_event(MODE_FREE, 48'h8000, '0, '0, '0);
		send_event(MODE_FREE, ADDR_TOP, '0, '0, '0);
		send_event(MODE_ALLOC, 48'h8000_0000_0000, '0, 32'h8000_0000, '0);
		send_event(MODE_REALLOC, 48'h8000_0000_0000, 48'h8000_0000_0000, 32'd1, '0);
		wait_results_drained();

		// fill, drain and mixed phases; some phases run without idling
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			gaps_on = (phase % 4 != 1);
			span = $urandom_range(120, 220);
			repeat (span) begin
				if (sent < RANDOM_ITEMS)
					random_event(phase % 3);
			end
			wait_results_drained();
			phase++;
		end

		gaps_on = 1'b0;
		repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);
		if (failures == 0)
			$display("allocation_tracking_table verification clean");
		else
			$display("allocation_tracking_table verification failed");
		$finish;
	end

endmodule

>>> allocation_tracking_table.f
hw/rtl/att_pkg.sv
hw/rtl/att_ram.sv
hw/rtl/att_ctrl.sv
hw/rtl/att_datapath.sv
hw/rtl/allocation_tracking_table.sv
tb/att_event_checker.sv
tb/tb_allocation_tracking_table.sv
